>>> sv/erg_pkg.sv
package erg_pkg;

    // Command codes carried in tuser
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_SET   = 2'd1;
    localparam logic [1:0] CMD_TIMER = 2'd2;

    // Stall outcome reported by the core
    localparam logic [1:0] STALL_DRAW = 2'd1;
    localparam logic [1:0] STALL_KEY  = 2'd2;

    // Setting selector
    localparam logic [1:0] SET_PAUSE = 2'd0;
    localparam logic [1:0] SET_DRAW  = 2'd1;
    localparam logic [1:0] SET_WAIT  = 2'd2;
    localparam logic [1:0] SET_STEP  = 2'd3;

    // Per-key tracker states
    localparam logic [1:0] TRK_HELD    = 2'd0;
    localparam logic [1:0] TRK_UP      = 2'd1;
    localparam logic [1:0] TRK_PRESSED = 2'd2;
    localparam logic [1:0] TRK_DONE    = 2'd3;

    // Physical key lines and default key count
    localparam int HEX_KEYS         = 16;
    localparam int NUM_KEYS_DEFAULT = 16;

    // Output register occupancy
    typedef enum logic {
        ST_EMPTY,
        ST_FULL
    } ctrl_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic step_en;
    } dp_cmd_t;

endpackage

>>> sv/erg_ctrl.sv
module erg_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output erg_pkg::dp_cmd_t dp_cmd
);

    erg_pkg::ctrl_state_t state_reg;
    erg_pkg::ctrl_state_t state_next;
    logic                 accept;

    // Take a beat when the result register is free or drains this cycle
    assign accept = in_valid && in_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            erg_pkg::ST_EMPTY:
            begin
                if (accept)
                    state_next = erg_pkg::ST_FULL;
            end
            erg_pkg::ST_FULL:
            begin
                if (accept)
                    state_next = erg_pkg::ST_FULL;
                else if (out_ready)
                    state_next = erg_pkg::ST_EMPTY;
            end
            default:
            begin
                state_next = erg_pkg::ST_EMPTY;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready       = 1'b1;
        out_valid      = 1'b0;
        dp_cmd.step_en = 1'b0;
        case (state_reg)
            erg_pkg::ST_EMPTY:
            begin
                in_ready       = 1'b1;
                out_valid      = 1'b0;
                dp_cmd.step_en = in_valid;
            end
            erg_pkg::ST_FULL:
            begin
                in_ready       = out_ready;
                out_valid      = 1'b1;
                dp_cmd.step_en = in_valid && out_ready;
            end
            default:
            begin
                in_ready       = 1'b0;
                out_valid      = 1'b0;
                dp_cmd.step_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= erg_pkg::ST_EMPTY;
        else
            state_reg <= state_next;
    end

endmodule

>>> sv/erg_datapath.sv
module erg_datapath
#(
    parameter int NUM_KEYS = erg_pkg::NUM_KEYS_DEFAULT
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  erg_pkg::dp_cmd_t dp_cmd,
    input  logic [1:0]       cmd,
    input  logic [1:0]       setting_type,
    input  logic [15:0]      key_down,
    input  logic [1:0]       exec_stall,
    input  logic [3:0]       key_reg,
    input  logic             on_off,
    output logic             executed,
    output logic             key_written,
    output logic [3:0]       key_value,
    output logic [3:0]       key_target,
    output logic             step_paused,
    output logic             draw_stalled,
    output logic             waiting_key,
    output logic             single_step
);

    // Machine state
    logic [1:0]          track_reg [NUM_KEYS];
    logic [1:0]          track_next [NUM_KEYS];
    logic                pause_reg, pause_next;
    logic                draw_reg, draw_next;
    logic                wait_reg, wait_next;
    logic                step_reg, step_next;
    logic [3:0]          saved_reg, saved_next;

    // Result register
    logic                executed_reg, executed_next;
    logic                written_reg, written_next;
    logic [3:0]          kval_reg, kval_next;
    logic [3:0]          ktgt_reg, ktgt_next;

    // Per-key working values
    logic [NUM_KEYS-1:0] held_vec;
    logic [1:0]          trk_new [NUM_KEYS];
    logic [NUM_KEYS-1:0] hit;
    logic [NUM_KEYS-1:0] upd_en;
    logic                found;
    logic [3:0]          pick;

    // Keys beyond the physical lines always read as up
    always_comb
    begin
        held_vec = '0;
        for (int i = 0; i < NUM_KEYS; i++)
        begin
            if (i < erg_pkg::HEX_KEYS)
                held_vec[i] = key_down[4'(i)];
        end
    end

    // Tracker step for every key in parallel
    always_comb
    begin
        for (int i = 0; i < NUM_KEYS; i++)
        begin
            trk_new[i] = track_reg[i];
            case (track_reg[i])
                erg_pkg::TRK_HELD:    if (!held_vec[i]) trk_new[i] = erg_pkg::TRK_UP;
                erg_pkg::TRK_UP:      if (held_vec[i])  trk_new[i] = erg_pkg::TRK_PRESSED;
                erg_pkg::TRK_PRESSED: if (!held_vec[i]) trk_new[i] = erg_pkg::TRK_DONE;
                default:              trk_new[i] = track_reg[i];
            endcase
            hit[i] = (trk_new[i] == erg_pkg::TRK_DONE);
        end
    end

    // Lowest completed key wins; keys above it hold this tick
    always_comb
    begin
        found = 1'b0;
        pick  = '0;
        for (int i = 0; i < NUM_KEYS; i++)
        begin
            upd_en[i] = !found;
            if (!found && hit[i])
            begin
                found = 1'b1;
                pick  = 4'(i);
            end
        end
    end

    // Command decode and state update
    always_comb
    begin
        track_next    = track_reg;
        pause_next    = pause_reg;
        draw_next     = draw_reg;
        wait_next     = wait_reg;
        step_next     = step_reg;
        saved_next    = saved_reg;
        executed_next = 1'b0;
        written_next  = 1'b0;
        kval_next     = '0;
        ktgt_next     = '0;
        case (cmd)
            erg_pkg::CMD_TICK:
            begin
                if (draw_reg)
                begin
                    executed_next = 1'b0;
                end
                else if (pause_reg && !step_reg)
                begin
                    executed_next = 1'b0;
                end
                else if (!wait_reg)
                begin
                    executed_next = 1'b1;
                    step_next     = 1'b0;
                    if (exec_stall == erg_pkg::STALL_KEY)
                    begin
                        wait_next  = 1'b1;
                        saved_next = key_reg;
                        for (int i = 0; i < NUM_KEYS; i++)
                            track_next[i] = held_vec[i] ? erg_pkg::TRK_HELD : erg_pkg::TRK_UP;
                    end
                    else if (exec_stall == erg_pkg::STALL_DRAW)
                    begin
                        draw_next = 1'b1;
                    end
                end
                else
                begin
                    for (int i = 0; i < NUM_KEYS; i++)
                    begin
                        if (upd_en[i])
                            track_next[i] = trk_new[i];
                    end
                    if (found)
                    begin
                        written_next = 1'b1;
                        kval_next    = pick;
                        ktgt_next    = saved_reg;
                        wait_next    = 1'b0;
                    end
                end
            end
            erg_pkg::CMD_SET:
            begin
                case (setting_type)
                    erg_pkg::SET_PAUSE: pause_next = on_off;
                    erg_pkg::SET_DRAW:  draw_next  = on_off;
                    erg_pkg::SET_WAIT:  wait_next  = on_off;
                    default:            step_next  = on_off;
                endcase
            end
            erg_pkg::CMD_TIMER:
            begin
                draw_next = 1'b0;
            end
            default:
            begin
                executed_next = 1'b0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_KEYS; i++)
                track_reg[i] <= erg_pkg::TRK_HELD;
            pause_reg <= 1'b0;
            draw_reg  <= 1'b0;
            wait_reg  <= 1'b0;
            step_reg  <= 1'b0;
            saved_reg <= '0;
        end
        else if (dp_cmd.step_en)
        begin
            track_reg <= track_next;
            pause_reg <= pause_next;
            draw_reg  <= draw_next;
            wait_reg  <= wait_next;
            step_reg  <= step_next;
            saved_reg <= saved_next;
        end
    end

    // Result payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            executed_reg <= 1'b0;
            written_reg  <= 1'b0;
            kval_reg     <= '0;
            ktgt_reg     <= '0;
        end
        else if (dp_cmd.step_en)
        begin
            executed_reg <= executed_next;
            written_reg  <= written_next;
            kval_reg     <= kval_next;
            ktgt_reg     <= ktgt_next;
        end
    end

    assign executed     = executed_reg;
    assign key_written  = written_reg;
    assign key_value    = kval_reg;
    assign key_target   = ktgt_reg;
    assign step_paused  = pause_reg;
    assign draw_stalled = draw_reg;
    assign waiting_key  = wait_reg;
    assign single_step  = step_reg;

endmodule

>>> sv/emulator_run_gate_with_key_wait_top.sv
// Run gate for an emulated 16-key machine. Each input beat carries one command (tuser):
// an execution tick, a setting write or a display timer tick; every beat yields exactly
// one output beat with the execute/key-write outcome and the four flags after the
// command. The whole update is done in the accept cycle and lands in a single output
// register, so a beat is taken every clock while the output side keeps up, and still
// taken in the cycle that the pending result drains. Keys at index 16 and above
// (NUM_KEYS > 16) always read as up.
module emulator_run_gate_with_key_wait_top
#(
    parameter int NUM_KEYS = erg_pkg::NUM_KEYS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [15:0] key_down, [17:16] exec_stall, [21:18] key_reg, [22] on_off
    input  logic [23:0] s_axis_tdata,
    // [1:0] cmd, [3:2] setting_type
    input  logic [3:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] executed, [1] key_written, [5:2] key_value, [9:6] key_target,
    // [10] step_paused, [11] draw_stalled, [12] waiting_key, [13] single_step
    output logic [15:0] m_axis_tdata
);

    erg_pkg::dp_cmd_t dp_cmd;
    logic             executed;
    logic             key_written;
    logic [3:0]       key_value;
    logic [3:0]       key_target;
    logic             step_paused;
    logic             draw_stalled;
    logic             waiting_key;
    logic             single_step;

    erg_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .dp_cmd    (dp_cmd)
    );

    erg_datapath #(
        .NUM_KEYS (NUM_KEYS)
    ) u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .dp_cmd       (dp_cmd),
        .cmd          (s_axis_tuser[1:0]),
        .setting_type (s_axis_tuser[3:2]),
        .key_down     (s_axis_tdata[15:0]),
        .exec_stall   (s_axis_tdata[17:16]),
        .key_reg      (s_axis_tdata[21:18]),
        .on_off       (s_axis_tdata[22]),
        .executed     (executed),
        .key_written  (key_written),
        .key_value    (key_value),
        .key_target   (key_target),
        .step_paused  (step_paused),
        .draw_stalled (draw_stalled),
        .waiting_key  (waiting_key),
        .single_step  (single_step)
    );

    // Pack the result beat
    assign m_axis_tdata = {2'b00, single_step, waiting_key, draw_stalled, step_paused,
                           key_target, key_value, key_written, executed};

endmodule
